// File: rtl/fqs_pkg.sv
// Shared types and constants for the FIFO queue with associative search.
// No dependencies; used by every module of the block and by its checker.
`default_nettype none

package fqs_pkg;

    // Default queue depth, handed to the top level parameter
    localparam int QUEUE_DEPTH_DEF = 16;

    // Result field widths
    localparam int POS_W = 4;
    localparam int OCC_W = 5;
    localparam int DATA_W = 32;

    typedef enum logic [1:0] {
        OP_ENQ    = 2'd0,
        OP_DEQ    = 2'd1,
        OP_SEARCH = 2'd2,
        OP_NOP    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } state_t;

    // Per-cycle commands broadcast to every cell of the row
    typedef struct packed {
        logic shift;   // take the data of the next cell toward the rear
        logic load;    // write push_value into the cell at fill_idx
        logic cmp;     // capture data == search_key into the match flag
        logic mshift;  // take the match flag of the next cell
    } cell_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/fqs_cell.sv
// One storage cell of the queue row: a value and a match flag.
// Depends on fqs_pkg for the command struct and data width.
`default_nettype none

module fqs_cell #(
    parameter int IDX = 0,
    parameter int CW  = 5
) (
    input  wire logic                            clk,
    input  wire fqs_pkg::cell_ctrl_t             ctrl,
    input  wire logic [CW-1:0]                   fill_idx,
    input  wire logic signed [fqs_pkg::DATA_W-1:0] push_value,
    input  wire logic signed [fqs_pkg::DATA_W-1:0] search_key,
    input  wire logic signed [fqs_pkg::DATA_W-1:0] nbr_data,
    input  wire logic                            nbr_match,
    output logic signed [fqs_pkg::DATA_W-1:0]    data,
    output logic                                 match
);

    logic signed [fqs_pkg::DATA_W-1:0] data_reg;
    logic                              match_reg;

    // Value: shift toward the front on dequeue, load at the fill slot on enqueue
    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            data_reg <= nbr_data;
        end
        else if (ctrl.load && (fill_idx == CW'(IDX)))
        begin
            data_reg <= push_value;
        end
    end

    // Match flag: parallel compare, then shift toward the front during the scan
    always_ff @(posedge clk)
    begin
        if (ctrl.cmp)
        begin
            match_reg <= (data_reg == search_key);
        end
        else if (ctrl.mshift)
        begin
            match_reg <= nbr_match;
        end
    end

    assign data  = data_reg;
    assign match = match_reg;

endmodule

`default_nettype wire

// File: rtl/fifo_queue_with_search_unit.sv
// Top level of the FIFO queue with associative search: controller and cell row.
// Depends on fqs_pkg and fqs_cell.
//
// Usage:
//   A request is taken at a rising edge where start is high and busy is low;
//   op, push_value and search_key are sampled at that edge.
//   Every request gives exactly one result: done is high for one cycle while
//   status, popped_value, match_position and occupancy hold the result.
//   Enqueue, dequeue and the unused op code answer in the cycle after the
//   request and never raise busy, so one such request can be taken per cycle.
//   Search compares all held cells in parallel at the request edge, then
//   shifts the row of match flags toward the front one cell per cycle until
//   the front flag is set or the held entries are used up; done then reports
//   the match position, or not found. busy is high during the scan.
//   Dequeue moves every value one cell toward the front; enqueue writes the
//   cell just past the last held entry.
//   Reset empties the queue and clears done and busy; cell contents are not
//   cleared and are only read once written.
//   The receiver cannot stall: results must be taken in their cycle.
`default_nettype none

module fifo_queue_with_search_unit #(
    parameter int QUEUE_DEPTH = fqs_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic [1:0]                        op,
    input  wire logic signed [fqs_pkg::DATA_W-1:0] push_value,
    input  wire logic signed [fqs_pkg::DATA_W-1:0] search_key,
    output logic                                   done,
    output logic [1:0]                             status,
    output logic signed [fqs_pkg::DATA_W-1:0]      popped_value,
    output logic [fqs_pkg::POS_W-1:0]              match_position,
    output logic [fqs_pkg::OCC_W-1:0]              occupancy
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    fqs_pkg::state_t                    state_reg, state_next;
    logic [CW-1:0]                      count_reg, count_next;
    logic [CW-1:0]                      scan_reg, scan_next;
    logic                               done_reg, done_next;
    fqs_pkg::status_t                   status_reg, status_next;
    logic signed [fqs_pkg::DATA_W-1:0]  popped_reg, popped_next;
    logic [fqs_pkg::POS_W-1:0]          pos_reg, pos_next;
    logic [fqs_pkg::OCC_W-1:0]          occ_reg, occ_next;

    fqs_pkg::cell_ctrl_t                ctrl;
    logic                               accept;

    logic signed [fqs_pkg::DATA_W-1:0]  cell_data [QUEUE_DEPTH];
    logic                               cell_match [QUEUE_DEPTH];

    assign busy   = (state_reg != fqs_pkg::S_IDLE);
    assign accept = start && !busy;

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fqs_pkg::S_IDLE;
            count_reg <= '0;
            scan_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            scan_reg  <= scan_next;
            done_reg  <= done_next;
        end
    end

    // Result registers
    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        popped_reg <= popped_next;
        pos_reg    <= pos_next;
        occ_reg    <= occ_next;
    end

    // Next state, result and cell commands
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        scan_next   = scan_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        popped_next = popped_reg;
        pos_next    = pos_reg;
        occ_next    = occ_reg;
        ctrl        = '0;

        case (state_reg)
            fqs_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    status_next = fqs_pkg::ST_OK;
                    popped_next = '0;
                    pos_next    = '0;
                    occ_next    = fqs_pkg::OCC_W'(count_reg);
                    case (fqs_pkg::op_t'(op))
                        fqs_pkg::OP_ENQ:
                        begin
                            done_next = 1'b1;
                            if (count_reg == CW'(QUEUE_DEPTH))
                            begin
                                status_next = fqs_pkg::ST_FULL;
                            end
                            else
                            begin
                                ctrl.load  = 1'b1;
                                count_next = count_reg + 1'b1;
                                occ_next   = fqs_pkg::OCC_W'(count_next);
                            end
                        end
                        fqs_pkg::OP_DEQ:
                        begin
                            done_next = 1'b1;
                            if (count_reg == '0)
                            begin
                                status_next = fqs_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                ctrl.shift  = 1'b1;
                                popped_next = cell_data[0];
                                count_next  = count_reg - 1'b1;
                                occ_next    = fqs_pkg::OCC_W'(count_next);
                            end
                        end
                        fqs_pkg::OP_SEARCH:
                        begin
                            ctrl.cmp   = 1'b1;
                            scan_next  = '0;
                            state_next = fqs_pkg::S_SCAN;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            fqs_pkg::S_SCAN:
            begin
                if (scan_reg == count_reg)
                begin
                    // held entries used up without a match
                    done_next   = 1'b1;
                    status_next = fqs_pkg::ST_NOTFOUND;
                    pos_next    = '0;
                    state_next  = fqs_pkg::S_IDLE;
                end
                else if (cell_match[0])
                begin
                    done_next   = 1'b1;
                    status_next = fqs_pkg::ST_OK;
                    pos_next    = fqs_pkg::POS_W'(scan_reg);
                    state_next  = fqs_pkg::S_IDLE;
                end
                else
                begin
                    ctrl.mshift = 1'b1;
                    scan_next   = scan_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = fqs_pkg::S_IDLE;
            end
        endcase
    end

    // Row of cells, cell 0 at the front
    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        logic signed [fqs_pkg::DATA_W-1:0] nbr_data;
        logic                              nbr_match;

        if (i == QUEUE_DEPTH - 1)
        begin : g_last
            assign nbr_data  = cell_data[i];
            assign nbr_match = 1'b0;
        end
        else
        begin : g_mid
            assign nbr_data  = cell_data[i+1];
            assign nbr_match = cell_match[i+1];
        end

        fqs_cell #(
            .IDX (i),
            .CW  (CW)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .fill_idx   (count_reg),
            .push_value (push_value),
            .search_key (search_key),
            .nbr_data   (nbr_data),
            .nbr_match  (nbr_match),
            .data       (cell_data[i]),
            .match      (cell_match[i])
        );
    end

    assign done           = done_reg;
    assign status         = status_reg;
    assign popped_value   = popped_reg;
    assign match_position = pos_reg;
    assign occupancy      = occ_reg;

endmodule

`default_nettype wire

// File: rtl/fqs_checker.sv
// Port-level checks for the FIFO queue with associative search, bound to the top.
// Depends on fqs_pkg and fifo_queue_with_search_unit.
`default_nettype none

module fqs_checker (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              start,
    input wire logic                              busy,
    input wire logic                              done,
    input wire logic [1:0]                        status,
    input wire logic signed [fqs_pkg::DATA_W-1:0] popped_value,
    input wire logic [fqs_pkg::POS_W-1:0]         match_position,
    input wire logic [fqs_pkg::OCC_W-1:0]         occupancy
);

    // A result never shows while a search is still scanning
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    // Every request answers next cycle or starts a scan
    a_request_answer: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (done || busy))
        else $error("request neither answered nor scanning");

    // A scan only starts from a request
    a_busy_from_request: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without a request");

    // Empty dequeue reports an empty queue and no value
    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == fqs_pkg::ST_EMPTY) |-> (occupancy == '0 && popped_value == '0))
        else $error("empty status with data");

    // Failed search reports position zero
    a_notfound_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == fqs_pkg::ST_NOTFOUND) |-> (match_position == '0))
        else $error("not-found status with nonzero position");

endmodule

bind fifo_queue_with_search_unit fqs_checker u_fqs_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .done           (done),
    .status         (status),
    .popped_value   (popped_value),
    .match_position (match_position),
    .occupancy      (occupancy)
);

`default_nettype wire

// File: bench/tb_top.sv
// Self-checking bench for fifo_queue_with_search_unit: directed and random
// enqueue, dequeue, search and no-op requests, checked against a queue mirror.
// Depends on rtl/fqs_pkg.sv and rtl/fifo_queue_with_search_unit.sv.
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import fqs_pkg::*;

    localparam int DEPTH = QUEUE_DEPTH_DEF;
    localparam int ITEMS = 1800;
    localparam int IDLE_LIMIT = 4000;
    localparam int TAIL_CYCLES = DEPTH + 8;

    typedef logic signed [DATA_W-1:0] word_t;

    // One expected answer of the block
    typedef struct {
        status_t          st;
        word_t            popped;
        logic [POS_W-1:0] pos;
        logic [OCC_W-1:0] occ;
    } queue_answer_t;

    // Mirror of the queue contents; predicts the answer of every request
    class fifo_mirror;
        word_t         slots[DEPTH];
        int unsigned   head;
        int unsigned   tail;
        int unsigned   count;
        queue_answer_t answers_due[$];
        int unsigned   errors;

        function new();
            head = 0;
            tail = 0;
            count = 0;
            errors = 0;
        endfunction

        function int unsigned pending();
            return answers_due.size();
        endfunction

        // A value currently held, or a random one when empty
        function word_t some_held();
            int unsigned idx;
            if (count == 0)
                return word_t'($urandom);
            idx = (head + $urandom_range(0, count - 1)) % DEPTH;
            return slots[idx];
        endfunction

        function void note_request(op_t o, word_t pv, word_t key);
            queue_answer_t a;
            int unsigned   p;
            bit            found;
            a.st = ST_OK;
            a.popped = '0;
            a.pos = '0;
            found = 1'b0;
            case (o)
                OP_ENQ:
                begin
                    if (count >= DEPTH)
                        a.st = ST_FULL;
                    else
                    begin
                        slots[tail] = pv;
                        tail = (tail + 1) % DEPTH;
                        count++;
                    end
                end
                OP_DEQ:
                begin
                    if (count == 0)
                        a.st = ST_EMPTY;
                    else
                    begin
                        a.popped = slots[head];
                        head = (head + 1) % DEPTH;
                        count--;
                    end
                end
                OP_SEARCH:
                begin
                    // first match counted from the front
                    for (int unsigned i = 0; i < count && !found; i++)
                    begin
                        p = (head + i) % DEPTH;
                        if (slots[p] == key)
                        begin
                            found = 1'b1;
                            a.pos = i[POS_W-1:0];
                        end
                    end
                    if (!found)
                        a.st = ST_NOTFOUND;
                end
                default: ;
            endcase
            a.occ = count[OCC_W-1:0];
            answers_due.push_back(a);
        endfunction

        function void check_answer(logic [1:0] st, word_t popped,
                                   logic [POS_W-1:0] pos, logic [OCC_W-1:0] occ);
            queue_answer_t a;
            if (answers_due.size() == 0)
            begin
                $error("result with no request waiting: status %0d", st);
                errors++;
                return;
            end
            a = answers_due.pop_front();
            if (st !== a.st)
            begin
                $error("status expected %0d actual %0d", a.st, st);
                errors++;
            end
            if (popped !== a.popped)
            begin
                $error("popped_value expected %0d actual %0d", a.popped, popped);
                errors++;
            end
            if (pos !== a.pos)
            begin
                $error("match_position expected %0d actual %0d", a.pos, pos);
                errors++;
            end
            if (occ !== a.occ)
            begin
                $error("occupancy expected %0d actual %0d", a.occ, occ);
                errors++;
            end
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic [1:0]          op;
    word_t               push_value;
    word_t               search_key;
    logic                done;
    logic [1:0]          status;
    word_t               popped_value;
    logic [POS_W-1:0]    match_position;
    logic [OCC_W-1:0]    occupancy;

    fifo_mirror          mirror;
    int unsigned         idle_cycles = 0;

    fifo_queue_with_search_unit #(
        .QUEUE_DEPTH(DEPTH)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .op             (op),
        .push_value     (push_value),
        .search_key     (search_key),
        .done           (done),
        .status         (status),
        .popped_value   (popped_value),
        .match_position (match_position),
        .occupancy      (occupancy)
    );

    // Clock
    initial clk = 1'b0;
    always #4 clk = ~clk;

    // Monitor: check results, record accepted requests, watch for a hang
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                mirror.check_answer(status, popped_value, match_position, occupancy);
            if (start && !busy)
                mirror.note_request(op_t'(op), push_value, search_key);
            if (done || (start && !busy))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("fifo_queue_with_search_unit: mismatch");
                $finish;
            end
        end
    end

    // Drive one request from the falling edge; return once it is taken
    task automatic send_request(op_t o, word_t pv, word_t key, int unsigned gap);
        if (gap != 0)
        begin
            start = 1'b0;
            repeat (gap) @(negedge clk);
        end
        op = o;
        push_value = pv;
        search_key = key;
        start = 1'b1;
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
    endtask

    // Hold off until every outstanding result has come back
    task automatic drain_results();
        start = 1'b0;
        @(negedge clk);
        while (mirror.pending() != 0)
            @(negedge clk);
    endtask

    // Mostly short gaps, a few long ones
    function automatic int unsigned pick_gap(bit burst);
        int unsigned r;
        if (burst)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Small pool for duplicates, extremes, or anything
    function automatic word_t pick_value();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 5)
            return word_t'($urandom_range(0, 7)) - 3;
        if (r == 5)
        begin
            case ($urandom_range(0, 3))
                0: return 32'sh8000_0000;
                1: return 32'sh7fff_ffff;
                2: return 32'sh0;
                default: return -32'sd1;
            endcase
        end
        return word_t'($urandom);
    endfunction

    function automatic word_t pick_key();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return mirror.some_held();
        if (r < 7)
            return pick_value();
        return word_t'($urandom);
    endfunction

    // Operation mix by phase: 0 fill, 1 drain, 2 balanced
    function automatic op_t pick_op(int unsigned mode);
        int unsigned r;
        int unsigned w_enq;
        int unsigned w_deq;
        r = $urandom_range(0, 99);
        case (mode)
            0: begin w_enq = 55; w_deq = 15; end
            1: begin w_enq = 15; w_deq = 55; end
            default: begin w_enq = 33; w_deq = 30; end
        endcase
        if (r < w_enq)
            return OP_ENQ;
        if (r < w_enq + w_deq)
            return OP_DEQ;
        if (r < 97)
            return OP_SEARCH;
        return OP_NOP;
    endfunction

    initial
    begin
        int unsigned mode;
        bit          burst;
        op_t         o;

        start = 1'b0;
        op = OP_ENQ;
        push_value = '0;
        search_key = '0;
        rst_n = 1'b0;
        mode = 2;
        burst = 1'b0;
        mirror = new();

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty queue cases and the unused op code
        send_request(OP_DEQ, 32'sh0, 32'sh0, 0);
        send_request(OP_SEARCH, 32'sh0, 32'sh0, 0);
        send_request(OP_NOP, 32'sh7fff_ffff, -32'sd1, 1);
        // Extreme values, then searches that hit and miss
        send_request(OP_ENQ, 32'sh7fff_ffff, 32'sh0, 0);
        send_request(OP_ENQ, 32'sh8000_0000, 32'sh0, 0);
        send_request(OP_ENQ, -32'sd1, 32'sh0, 0);
        send_request(OP_ENQ, 32'sh0, 32'sh0, 0);
        send_request(OP_SEARCH, 32'sh0, 32'sh8000_0000, 0);
        send_request(OP_SEARCH, -32'sd1, 32'sh0, 2);
        send_request(OP_SEARCH, 32'sh0, 32'sh1, 0);
        send_request(OP_DEQ, 32'sh0, 32'sh0, 0);
        // Fill to full, one dropped enqueue, search the rear, no-op while full
        while (mirror.count < DEPTH)
            send_request(OP_ENQ, word_t'(mirror.count) + 100, 32'sh0, 0);
        send_request(OP_ENQ, 32'sh5555_aaaa, 32'sh0, 0);
        send_request(OP_SEARCH, 32'sh0, word_t'(DEPTH - 1) + 100, 0);
        send_request(OP_NOP, 32'sh0, 32'sh0, 0);
        drain_results();

        // Random phases
        for (int i = 0; i < ITEMS; i++)
        begin
            if (i % 150 == 0)
            begin
                mode = $urandom_range(0, 2);
                burst = ($urandom_range(0, 3) == 0);
            end
            if (i % 450 == 449)
                drain_results();
            o = pick_op(mode);
            send_request(o, pick_value(), pick_key(), pick_gap(burst));
        end

        // Wait out all results, then the longest scan
        start = 1'b0;
        while (mirror.pending() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mirror.errors == 0)
            $display("fifo_queue_with_search_unit: match");
        else
            $display("fifo_queue_with_search_unit: mismatch");
        $finish;
    end

endmodule

`default_nettype wire

// File: sim.f
rtl/fqs_pkg.sv
rtl/fqs_cell.sv
rtl/fifo_queue_with_search_unit.sv
rtl/fqs_checker.sv
bench/tb_top.sv
